// ----- sv/sfd_pkg.sv -----
// Shared types, codes and the byte-wide CRC step of the stuffed frame decoder.
// No dependencies; used by every sfd_* module and the top level.
`default_nettype none

package sfd_pkg;

  localparam int BODY_DEPTH_DEF = 64;
  localparam int Q_DEPTH        = 2;

  // configuration register indexes
  localparam logic [2:0] CFG_START  = 3'd0;
  localparam logic [2:0] CFG_END    = 3'd1;
  localparam logic [2:0] CFG_ESCAPE = 3'd2;
  localparam logic [2:0] CFG_MASK   = 3'd3;
  localparam logic [2:0] CFG_POLY   = 3'd4;
  localparam logic [2:0] CFG_SEED   = 3'd5;

  // frame_status codes
  localparam logic [1:0] ST_NONE   = 2'd0;
  localparam logic [1:0] ST_GOOD   = 2'd1;
  localparam logic [1:0] ST_REJECT = 2'd2;

  // error_kind codes
  localparam logic [1:0] ERR_NONE  = 2'd0;
  localparam logic [1:0] ERR_FRAME = 2'd1;
  localparam logic [1:0] ERR_CRC   = 2'd2;

  // operation codes passed from front to back
  localparam logic [2:0] OP_NONE  = 3'd0;
  localparam logic [2:0] OP_START = 3'd1;
  localparam logic [2:0] OP_DATA  = 3'd2;
  localparam logic [2:0] OP_CLOSE = 3'd3;
  localparam logic [2:0] OP_READ  = 3'd4;

  typedef struct packed {
    logic [7:0]  start_code;
    logic [7:0]  end_code;
    logic [7:0]  escape_code;
    logic [7:0]  stuff_mask;
    logic [15:0] crc_polynomial;
    logic [15:0] crc_seed;
  } cfg_t;

  typedef struct packed {
    logic [2:0] kind;
    logic       esc;   // escape still pending at close
    logic [7:0] data;  // unstuffed body byte
    logic [5:0] idx;   // payload read position
  } op_t;

  // MSB-first CRC-16 update over one byte
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b,
                                           input logic [15:0] poly);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      c = c[15] ? ((c << 1) ^ poly) : (c << 1);
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// ----- sv/sfd_front.sv -----
// Front end: tracks frame and escape state, unstuffs bytes, classifies each transaction.
// Depends on sfd_pkg.
`default_nettype none

module sfd_front (
  input  wire              clk,
  input  wire              rst_n,
  input  sfd_pkg::cfg_t    cfg,
  input  wire              in_valid,
  output logic             in_ready,
  input  wire              in_mode,
  input  wire  [7:0]       in_line_byte,
  input  wire  [5:0]       in_read_index,
  input  wire              q_full,
  output logic             q_push,
  output sfd_pkg::op_t     q_op
);

  logic inside_r, inside_nxt;
  logic esc_r, esc_nxt;

  assign in_ready = !q_full;
  assign q_push   = in_valid && in_ready;

  always_comb begin
    inside_nxt = inside_r;
    esc_nxt    = esc_r;
    q_op.kind  = sfd_pkg::OP_NONE;
    q_op.esc   = esc_r;
    q_op.data  = in_line_byte;
    q_op.idx   = in_read_index;
    if (in_mode) begin
      q_op.kind = sfd_pkg::OP_READ;
    end else if (in_line_byte == cfg.start_code) begin
      q_op.kind  = sfd_pkg::OP_START;
      inside_nxt = 1'b1;
      esc_nxt    = 1'b0;
    end else if (!inside_r) begin
      q_op.kind = sfd_pkg::OP_NONE;
    end else if (in_line_byte == cfg.end_code) begin
      q_op.kind  = sfd_pkg::OP_CLOSE;
      inside_nxt = 1'b0;
    end else if (esc_r) begin
      q_op.kind = sfd_pkg::OP_DATA;
      q_op.data = in_line_byte ^ cfg.stuff_mask;
      esc_nxt   = 1'b0;
    end else if (in_line_byte == cfg.escape_code) begin
      q_op.kind = sfd_pkg::OP_NONE;
      esc_nxt   = 1'b1;
    end else begin
      q_op.kind = sfd_pkg::OP_DATA;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inside_r <= 1'b0;
      esc_r    <= 1'b0;
    end else if (q_push) begin
      inside_r <= inside_nxt;
      esc_r    <= esc_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- sv/sfd_queue.sv -----
// Short operation queue between front and back end.
// Depends on sfd_pkg (op_t, Q_DEPTH).
`default_nettype none

module sfd_queue (
  input  wire           clk,
  input  wire           rst_n,
  input  wire           push,
  input  sfd_pkg::op_t  push_op,
  output logic          full,
  input  wire           pop,
  output sfd_pkg::op_t  pop_op,
  output logic          empty
);

  localparam int PTRW = (sfd_pkg::Q_DEPTH > 1) ? $clog2(sfd_pkg::Q_DEPTH) : 1;
  localparam int CNTW = $clog2(sfd_pkg::Q_DEPTH + 1);

  sfd_pkg::op_t  slot_r [sfd_pkg::Q_DEPTH];
  logic [PTRW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNTW-1:0] cnt_r;

  assign full   = (cnt_r == CNTW'(sfd_pkg::Q_DEPTH));
  assign empty  = (cnt_r == '0);
  assign pop_op = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_op;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTRW'(sfd_pkg::Q_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTRW'(sfd_pkg::Q_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ----- sv/sfd_back.sv -----
// Back end: body store, length/CRC check, last-good-frame registers and result register.
// Depends on sfd_pkg.
`default_nettype none

module sfd_back #(
  parameter int BODY_DEPTH = sfd_pkg::BODY_DEPTH_DEF
) (
  input  wire              clk,
  input  wire              rst_n,
  input  sfd_pkg::cfg_t    cfg,
  input  wire              q_empty,
  input  sfd_pkg::op_t     q_op,
  output logic             q_pop,
  output logic             out_valid,
  input  wire              out_ready,
  output logic [1:0]       out_frame_status,
  output logic [1:0]       out_error_kind,
  output logic [7:0]       out_frame_seq,
  output logic [7:0]       out_frame_cmd,
  output logic [5:0]       out_payload_length,
  output logic [7:0]       out_read_data
);

  localparam int CW = $clog2(BODY_DEPTH + 1);
  localparam int AW = $clog2(BODY_DEPTH);
  localparam int PW = ((CW > 7) ? CW : 7) + 1;

  logic [7:0]    mem [BODY_DEPTH];
  logic [7:0]    rd_q_r;
  logic [7:0]    hdr_r [4];

  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          ovf_r, ovf_nxt;
  logic [15:0]   crc_r, crc_nxt;
  logic [15:0]   dly_r, dly_nxt;
  logic [7:0]    seq_r, seq_nxt;
  logic [7:0]    cmd_r, cmd_nxt;
  logic [CW-1:0] glen_r, glen_nxt;
  logic [1:0]    outcome_r, outcome_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [1:0]    status_r, status_nxt;
  logic          rd_flag_r;

  logic          room;
  logic          mem_we;
  logic          rd_en;
  logic [15:0]   len;
  logic [15:0]   glen16;
  logic [PW-1:0] pos;

  assign q_pop  = !q_empty && (!out_valid_r || out_ready);
  assign room   = (cnt_r < CW'(BODY_DEPTH));
  assign mem_we = q_pop && (q_op.kind == sfd_pkg::OP_DATA) && room;
  assign len    = {hdr_r[0], hdr_r[1]};
  assign glen16 = 16'(glen_r);
  assign pos    = PW'(q_op.idx) + PW'(4);
  assign rd_en  = q_pop && (q_op.kind == sfd_pkg::OP_READ)
                  && ({10'd0, q_op.idx} < glen16) && (pos < PW'(BODY_DEPTH));

  always_comb begin
    cnt_nxt     = cnt_r;
    ovf_nxt     = ovf_r;
    crc_nxt     = crc_r;
    dly_nxt     = dly_r;
    seq_nxt     = seq_r;
    cmd_nxt     = cmd_r;
    glen_nxt    = glen_r;
    outcome_nxt = outcome_r;
    status_nxt  = sfd_pkg::ST_NONE;
    unique case (q_op.kind)
      sfd_pkg::OP_START: begin
        cnt_nxt = '0;
        ovf_nxt = 1'b0;
        crc_nxt = cfg.crc_seed;
        dly_nxt = '0;
      end
      sfd_pkg::OP_DATA: begin
        if (!room) begin
          ovf_nxt = 1'b1;
        end else begin
          if (cnt_r >= CW'(4)) begin
            crc_nxt = sfd_pkg::crc_byte(crc_r, dly_r[15:8], cfg.crc_polynomial);
          end
          if (cnt_r >= CW'(2)) begin
            dly_nxt = {dly_r[7:0], q_op.data};
          end
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      sfd_pkg::OP_CLOSE: begin
        status_nxt = sfd_pkg::ST_REJECT;
        priority if (ovf_r || q_op.esc || cnt_r < CW'(6)) begin
          outcome_nxt = sfd_pkg::ERR_FRAME;
        end else if (({1'b0, len} + 17'd4 != 17'(cnt_r)) || len < 16'd2) begin
          outcome_nxt = sfd_pkg::ERR_FRAME;
        end else if (dly_r != crc_r) begin
          outcome_nxt = sfd_pkg::ERR_CRC;
        end else begin
          outcome_nxt = sfd_pkg::ERR_NONE;
          status_nxt  = sfd_pkg::ST_GOOD;
          seq_nxt     = hdr_r[2];
          cmd_nxt     = hdr_r[3];
          glen_nxt    = CW'(len - 16'd2);
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (q_pop) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // body store and header shadow
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[cnt_r[AW-1:0]] <= q_op.data;
    end
    if (mem_we && cnt_r < CW'(4)) begin
      hdr_r[cnt_r[1:0]] <= q_op.data;
    end
    if (rd_en) begin
      rd_q_r <= mem[pos[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      ovf_r       <= 1'b0;
      crc_r       <= 16'hFFFF;
      dly_r       <= '0;
      seq_r       <= '0;
      cmd_r       <= '0;
      glen_r      <= '0;
      outcome_r   <= sfd_pkg::ERR_NONE;
      out_valid_r <= 1'b0;
      status_r    <= sfd_pkg::ST_NONE;
      rd_flag_r   <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (q_pop) begin
        cnt_r     <= cnt_nxt;
        ovf_r     <= ovf_nxt;
        crc_r     <= crc_nxt;
        dly_r     <= dly_nxt;
        seq_r     <= seq_nxt;
        cmd_r     <= cmd_nxt;
        glen_r    <= glen_nxt;
        outcome_r <= outcome_nxt;
        status_r  <= status_nxt;
        rd_flag_r <= rd_en;
      end
    end
  end

  // state only moves at pops, so it always matches the held result
  assign out_valid          = out_valid_r;
  assign out_frame_status   = status_r;
  assign out_error_kind     = outcome_r;
  assign out_frame_seq      = seq_r;
  assign out_frame_cmd      = cmd_r;
  assign out_payload_length = glen16[5:0];
  assign out_read_data      = rd_flag_r ? rd_q_r : 8'd0;

`ifndef SYNTHESIS
  a_good_no_error: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && status_r == sfd_pkg::ST_GOOD |-> outcome_r == sfd_pkg::ERR_NONE)
    else $error("good frame reported with an error outcome");
  a_reject_has_error: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && status_r == sfd_pkg::ST_REJECT |-> outcome_r != sfd_pkg::ERR_NONE)
    else $error("rejected frame reported without an error outcome");
  a_read_no_status: assert property (@(posedge clk) disable iff (!rst_n)
    rd_flag_r |-> status_r == sfd_pkg::ST_NONE)
    else $error("read transaction carries a frame status");
  a_overflow_full: assert property (@(posedge clk) disable iff (!rst_n)
    ovf_r |-> cnt_r == CW'(BODY_DEPTH))
    else $error("overflow flagged before the body store filled");
`endif

endmodule

`default_nettype wire

// ----- sv/stuffed_frame_decoder_crc.sv -----
// Byte-stuffed STX/ETX frame decoder with CRC-16 check: top level.
// Holds the configuration registers; instantiates sfd_front, sfd_queue and sfd_back.
// Depends on sfd_pkg.
//
// Usage:
//   Input channel (in_valid/in_ready): in_mode 0 feeds one line byte, in_mode 1 reads
//   a payload byte of the last good frame at in_read_index. Every transaction gives
//   exactly one result on the output channel (out_valid/out_ready).
//   Output: frame status (nothing / good / rejected), sticky error kind, SEQ, CMD and
//   payload length of the last good frame, and read data for read transactions.
//   Configuration: cfg_we/cfg_index/cfg_wdata write one register per cycle; write only
//   while no transaction is in flight. Indexes past the last register are ignored.
// Timing:
//   out_valid rises once the accepted transaction has passed the queue into the result register.
//   Throughput is one transaction per cycle while out_ready is high, set by the combinational byte-wide
//   CRC update and body store write in the back end. A two-entry queue separates front and back end.
// Reset: synchronous rst_n clears frame state and restores register defaults; the body
//   store is not cleared, and reads only reach entries of the last good frame.
// Stall: the result register holds while out_ready is low; the queue keeps accepting
//   until full, then in_ready drops.
`default_nettype none

module stuffed_frame_decoder_crc #(
  parameter int BODY_DEPTH = sfd_pkg::BODY_DEPTH_DEF
) (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         cfg_we,
  input  wire  [2:0]  cfg_index,
  input  wire  [15:0] cfg_wdata,
  input  wire         in_valid,
  output logic        in_ready,
  input  wire         in_mode,
  input  wire  [7:0]  in_line_byte,
  input  wire  [5:0]  in_read_index,
  output logic        out_valid,
  input  wire         out_ready,
  output logic [1:0]  out_frame_status,
  output logic [1:0]  out_error_kind,
  output logic [7:0]  out_frame_seq,
  output logic [7:0]  out_frame_cmd,
  output logic [5:0]  out_payload_length,
  output logic [7:0]  out_read_data
);

  sfd_pkg::cfg_t cfg_r;
  sfd_pkg::op_t  push_op, pop_op;
  logic          q_full, q_empty, q_push, q_pop;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.start_code     <= 8'd2;
      cfg_r.end_code       <= 8'd3;
      cfg_r.escape_code    <= 8'd16;
      cfg_r.stuff_mask     <= 8'd32;
      cfg_r.crc_polynomial <= 16'h1021;
      cfg_r.crc_seed       <= 16'hFFFF;
    end else if (cfg_we) begin
      unique case (cfg_index)
        sfd_pkg::CFG_START:  cfg_r.start_code     <= cfg_wdata[7:0];
        sfd_pkg::CFG_END:    cfg_r.end_code       <= cfg_wdata[7:0];
        sfd_pkg::CFG_ESCAPE: cfg_r.escape_code    <= cfg_wdata[7:0];
        sfd_pkg::CFG_MASK:   cfg_r.stuff_mask     <= cfg_wdata[7:0];
        sfd_pkg::CFG_POLY:   cfg_r.crc_polynomial <= cfg_wdata;
        sfd_pkg::CFG_SEED:   cfg_r.crc_seed       <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  sfd_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg           (cfg_r),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_mode       (in_mode),
    .in_line_byte  (in_line_byte),
    .in_read_index (in_read_index),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_op          (push_op)
  );

  sfd_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .push_op (push_op),
    .full    (q_full),
    .pop     (q_pop),
    .pop_op  (pop_op),
    .empty   (q_empty)
  );

  sfd_back #(
    .BODY_DEPTH (BODY_DEPTH)
  ) u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg                (cfg_r),
    .q_empty            (q_empty),
    .q_op               (pop_op),
    .q_pop              (q_pop),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_frame_status   (out_frame_status),
    .out_error_kind     (out_error_kind),
    .out_frame_seq      (out_frame_seq),
    .out_frame_cmd      (out_frame_cmd),
    .out_payload_length (out_payload_length),
    .out_read_data      (out_read_data)
  );

endmodule

`default_nettype wire
